@@ design/tsasf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsasf_pkg
// Shared widths, register indexes and types of the average-and-snap filter.
// ----------------------------------------------------------------------------
package tsasf_pkg;

   localparam int RAW_W  = 12;   // raw sample word
   localparam int FS_W   = 12;   // full scale register
   localparam int POS_W  = 7;    // hundredths, 0..100
   localparam int THR_W  = 7;
   localparam int DIV_W  = 20;   // holds 201 * 4095
   localparam int DVS_W  = 13;   // holds 2 * 4095
   localparam int STEP_W = $clog2(POS_W);

   localparam int ADC_BITS = 12;
   localparam logic [RAW_W-1:0] ADC_MASK =
      (ADC_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((1 << ADC_BITS) - 1);

   localparam logic [POS_W-1:0] FULL_POS = POS_W'(100);
   localparam logic [7:0]       NORM_MUL = 8'd200;

   localparam int SAMPLES_PER_BLOCK_DEF = 8;
   localparam int BLOCKS_PER_WINDOW_DEF = 8;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd2;

   typedef enum logic [1:0] {
      KIND_SKIP = 2'd0,   // disabled: return held position only
      KIND_FULL = 2'd1,   // above full scale: saturates
      KIND_NORM = 2'd2    // needs the normalising divide
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [RAW_W-1:0] raw;
   } entry_type;

endpackage : tsasf_pkg
`default_nettype wire

@@ design/two_stage_average_snap_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// two_stage_average_snap_filter
// Potentiometer filter: block means, window mean, snap to window min or max.
//
// req_ channel carries one raw ADC word per handshake; rsp_ returns one word
// per accepted sample, in order: the held position and a fresh flag that is
// set when that sample closed a window. csr_ writes enable, full scale and
// snap threshold; the user must write them only while the block is idle, as
// the block itself does not enforce it. A word that needs no divide goes from
// ST_IDLE to ST_DONE; one that needs the normalising divide waits in ST_NORM
// first, and closing a block adds ST_BLOCK and closing a window ST_WIN. The
// divide is a 7-step serial divider with a registered done; block and window
// means come from combinational reciprocal multiplies. The back end takes one
// word at a time; a two-word queue in front accepts new words while the back
// end works or a result waits. Reset clears the queue, the indexes, the held
// position and the output, and loads enable 1, full scale 4095, threshold 1.
// A stalled receiver holds the result register; the queue then fills and
// req_ready drops.
// ----------------------------------------------------------------------------
module two_stage_average_snap_filter
   import tsasf_pkg::*;
#(
   parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF,
   parameter int BLOCKS_PER_WINDOW = BLOCKS_PER_WINDOW_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [RAW_W-1:0]     req_raw_sample,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [POS_W-1:0]          rsp_position,
   output logic                      rsp_fresh,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   logic             enable_ff, enable_in;
   logic [FS_W-1:0]  full_scale_ff, full_scale_in;
   logic [THR_W-1:0] threshold_ff, threshold_in;
   logic [FS_W-1:0]  fs_eff;
   logic             q_valid;
   entry_type        q_entry;
   logic             q_pop;

   assign fs_eff = (full_scale_ff == '0) ? FS_W'(1) : full_scale_ff;

   always_comb begin
      enable_in     = enable_ff;
      full_scale_in = full_scale_ff;
      threshold_in  = threshold_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:     enable_in     = csr_wdata[0];
            CSR_FULL_SCALE: full_scale_in = csr_wdata[FS_W-1:0];
            CSR_THRESHOLD:  threshold_in  = csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b1;
         full_scale_ff <= FS_W'(4095);
         threshold_ff  <= THR_W'(1);
      end else begin
         enable_ff     <= enable_in;
         full_scale_ff <= full_scale_in;
         threshold_ff  <= threshold_in;
      end
   end

   tsasf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_raw_sample (req_raw_sample),
      .cfg_enable     (enable_ff),
      .fs_eff         (fs_eff),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop)
   );

   tsasf_back #(
      .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
      .BLOCKS_PER_WINDOW (BLOCKS_PER_WINDOW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop),
      .fs_eff        (fs_eff),
      .cfg_threshold (threshold_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_position  (rsp_position),
      .rsp_fresh     (rsp_fresh)
   );

endmodule : two_stage_average_snap_filter
`default_nettype wire

@@ design/tsasf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsasf_front
// Accepts sample words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module tsasf_front
   import tsasf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [RAW_W-1:0] req_raw_sample,
   input  wire logic             cfg_enable,
   input  wire logic [FS_W-1:0]  fs_eff,
   output logic                  q_valid,
   output entry_type             q_entry,
   input  wire logic             q_pop
);

   entry_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;
   entry_type  new_entry;
   logic [RAW_W-1:0] raw_m;

   assign raw_m     = req_raw_sample & ADC_MASK;
   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_entry   = mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      new_entry.raw = raw_m;
      if (!cfg_enable) begin
         new_entry.kind = KIND_SKIP;
      end else if (raw_m > fs_eff) begin
         new_entry.kind = KIND_FULL;
      end else begin
         new_entry.kind = KIND_NORM;
      end
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule : tsasf_front
`default_nettype wire

@@ design/tsasf_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsasf_div
// Restoring serial divider, one quotient bit per cycle; quotient below 128.
// ----------------------------------------------------------------------------
module tsasf_div
   import tsasf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [POS_W-1:0]      quot
);

   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic [POS_W-1:0]  quot_ff, quot_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   assign done = done_ff;
   assign quot = quot_ff;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dvs_in  = DIV_W'(divisor) << (POS_W - 1);
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dvs_ff) begin
            rem_in  = rem_ff - dvs_ff;
            quot_in = {quot_ff[POS_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[POS_W-2:0], 1'b0};
         end
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(POS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

endmodule : tsasf_div
`default_nettype wire

@@ design/tsasf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsasf_back
// Sequencer: normalises a sample through the serial divider, builds block and
// window means by reciprocal multiply, snaps the held position and drives the
// result register.
// ----------------------------------------------------------------------------
module tsasf_back
   import tsasf_pkg::*;
#(
   parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF,
   parameter int BLOCKS_PER_WINDOW = BLOCKS_PER_WINDOW_DEF
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire entry_type        q_entry,
   output logic                  q_pop,
   input  wire logic [FS_W-1:0]  fs_eff,
   input  wire logic [THR_W-1:0] cfg_threshold,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [POS_W-1:0]      rsp_position,
   output logic                  rsp_fresh
);

   localparam int SI_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
   localparam int BI_W = (BLOCKS_PER_WINDOW > 1) ? $clog2(BLOCKS_PER_WINDOW) : 1;
   localparam int BS_W = $clog2(100 * SAMPLES_PER_BLOCK + 1);
   localparam int WS_W = $clog2(100 * BLOCKS_PER_WINDOW + 1);
   localparam int BX_W = $clog2(201 * SAMPLES_PER_BLOCK + 1);
   localparam int WX_W = $clog2(201 * BLOCKS_PER_WINDOW + 1);

   // mean = (2*sum + n) / (2*n) as (x * ceil(2^S / 2n)) >> S, exact for x < 2^15
   localparam int RCP_S  = 22;
   localparam int BP_W   = BX_W + RCP_S;
   localparam int WP_W   = WX_W + RCP_S;
   localparam int BM_RCP = ((1 << RCP_S) + 2 * SAMPLES_PER_BLOCK - 1) /
                           (2 * SAMPLES_PER_BLOCK);
   localparam int WM_RCP = ((1 << RCP_S) + 2 * BLOCKS_PER_WINDOW - 1) /
                           (2 * BLOCKS_PER_WINDOW);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_NORM  = 5'b00010,
      ST_BLOCK = 5'b00100,
      ST_WIN   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [SI_W-1:0]  samp_idx_ff, samp_idx_in;
   logic [BI_W-1:0]  blk_idx_ff, blk_idx_in;
   logic [BS_W-1:0]  bsum_ff, bsum_in;
   logic [WS_W-1:0]  wsum_ff, wsum_in;
   logic [POS_W-1:0] lo_ff, lo_in;
   logic [POS_W-1:0] hi_ff, hi_in;
   logic [POS_W-1:0] held_ff, held_in;
   logic             fresh_ff, fresh_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_position_ff, rsp_position_in;
   logic             rsp_fresh_ff, rsp_fresh_in;

   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DVS_W-1:0] div_divisor;
   logic             div_done;
   logic [POS_W-1:0] div_quot;

   logic             acc_go;
   logic [POS_W-1:0] acc_val;
   logic [BS_W-1:0]  bsum_new;
   logic [WS_W-1:0]  wsum_new;
   logic [POS_W-1:0] lo_new;
   logic [POS_W-1:0] hi_new;
   logic [POS_W-1:0] gap;
   logic             out_free;
   logic [BX_W-1:0]  bnum;
   logic [BP_W-1:0]  bprod;
   logic [POS_W-1:0] blk_mean;
   logic [WX_W-1:0]  wnum;
   logic [WP_W-1:0]  wprod;
   logic [POS_W-1:0] win_mean;

   tsasf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_fresh    = rsp_fresh_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign q_pop        = (state_ff == ST_IDLE) && q_valid;

   assign acc_go  = ((state_ff == ST_IDLE) && q_valid && (q_entry.kind == KIND_FULL)) ||
                    ((state_ff == ST_NORM) && div_done);
   assign acc_val = (state_ff == ST_NORM) ? div_quot : FULL_POS;

   assign bnum     = BX_W'({bsum_ff, 1'b0}) + BX_W'(SAMPLES_PER_BLOCK);
   assign bprod    = BP_W'(bnum) * BP_W'(BM_RCP);
   assign blk_mean = bprod[RCP_S +: POS_W];
   assign wnum     = WX_W'({wsum_ff, 1'b0}) + WX_W'(BLOCKS_PER_WINDOW);
   assign wprod    = WP_W'(wnum) * WP_W'(WM_RCP);
   assign win_mean = wprod[RCP_S +: POS_W];

   assign bsum_new = ((samp_idx_ff == '0) ? '0 : bsum_ff) + BS_W'(acc_val);
   assign wsum_new = ((blk_idx_ff == '0) ? '0 : wsum_ff) + WS_W'(blk_mean);
   assign lo_new   = ((blk_idx_ff == '0) || (blk_mean < lo_ff)) ? blk_mean : lo_ff;
   assign hi_new   = ((blk_idx_ff == '0) || (blk_mean > hi_ff)) ? blk_mean : hi_ff;
   assign gap      = (win_mean >= lo_ff) ? (win_mean - lo_ff) : (lo_ff - win_mean);

   always_comb begin
      state_in        = state_ff;
      samp_idx_in     = samp_idx_ff;
      blk_idx_in      = blk_idx_ff;
      bsum_in         = bsum_ff;
      wsum_in         = wsum_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      held_in         = held_ff;
      fresh_in        = fresh_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_position_in = rsp_position_ff;
      rsp_fresh_in    = rsp_fresh_ff;
      div_start       = 1'b0;
      div_dividend    = DIV_W'(q_entry.raw) * DIV_W'(NORM_MUL) + DIV_W'(fs_eff);
      div_divisor     = {fs_eff, 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_entry.kind)
                  KIND_SKIP: begin
                     fresh_in = 1'b0;
                     state_in = ST_DONE;
                  end
                  KIND_NORM: begin
                     div_start = 1'b1;
                     state_in  = ST_NORM;
                  end
                  default: ;
               endcase
            end
         end
         ST_BLOCK: begin
            wsum_in = wsum_new;
            lo_in   = lo_new;
            hi_in   = hi_new;
            if (blk_idx_ff == BI_W'(BLOCKS_PER_WINDOW - 1)) begin
               blk_idx_in = '0;
               state_in   = ST_WIN;
            end else begin
               blk_idx_in = blk_idx_ff + BI_W'(1);
               fresh_in   = 1'b0;
               state_in   = ST_DONE;
            end
         end
         ST_WIN: begin
            held_in  = (gap <= cfg_threshold) ? lo_ff : hi_ff;
            fresh_in = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = held_ff;
               rsp_fresh_in    = fresh_ff;
               state_in        = ST_IDLE;
            end
         end
         default: ;
      endcase

      // sample value ready: saturated word or normalising divide finished
      if (acc_go) begin
         bsum_in = bsum_new;
         if (samp_idx_ff == SI_W'(SAMPLES_PER_BLOCK - 1)) begin
            samp_idx_in = '0;
            state_in    = ST_BLOCK;
         end else begin
            samp_idx_in = samp_idx_ff + SI_W'(1);
            fresh_in    = 1'b0;
            state_in    = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         samp_idx_ff  <= '0;
         blk_idx_ff   <= '0;
         held_ff      <= '0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         samp_idx_ff  <= samp_idx_in;
         blk_idx_ff   <= blk_idx_in;
         held_ff      <= held_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bsum_ff         <= bsum_in;
      wsum_ff         <= wsum_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      rsp_position_ff <= rsp_position_in;
      rsp_fresh_ff    <= rsp_fresh_in;
   end

endmodule : tsasf_back
`default_nettype wire

@@ sim/snap_filter_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// snap_filter_checker
// Watches the req_, rsp_ and csr_ ports of the average-and-snap filter.
//
// Keeps a shadow of the registers and of the block and window stores, works
// out the word each accepted sample must return and queues it. Each returned
// word is compared field by field with the oldest queued one. Unexpected
// words and wrong fields are counted as failures and handed to the top.
// ----------------------------------------------------------------------------
module snap_filter_checker
   import tsasf_pkg::*;
#(
   parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF,
   parameter int BLOCKS_PER_WINDOW = BLOCKS_PER_WINDOW_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic [RAW_W-1:0]     req_raw_sample,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [POS_W-1:0]     rsp_position,
   input  wire logic                 rsp_fresh,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   output int                        words_pending,
   output int                        fail_count
);

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             fresh;
   } filter_word_type;

   filter_word_type  expected_words [$];

   logic             shadow_enable;
   logic [FS_W-1:0]  shadow_full_scale;
   logic [THR_W-1:0] shadow_threshold;
   logic [POS_W-1:0] sample_hist [SAMPLES_PER_BLOCK];
   logic [POS_W-1:0] block_means [BLOCKS_PER_WINDOW];
   int unsigned      samp_fill;
   int unsigned      block_count;
   logic [POS_W-1:0] held_pos;
   int               mismatches;

   function automatic int unsigned rounded_div(int unsigned total, int unsigned count);
      return (2 * total + count) / (2 * count);
   endfunction

   function automatic logic [POS_W-1:0] to_hundredths(logic [RAW_W-1:0] raw,
                                                      logic [FS_W-1:0] fs);
      int unsigned scale;
      int unsigned level;
      scale = fs;
      if (scale == 0)
         scale = 1;
      level = raw & ADC_MASK;
      if (level > scale)
         return FULL_POS;
      return POS_W'((200 * level + scale) / (2 * scale));
   endfunction

   task automatic step_filter(input logic [RAW_W-1:0] raw, output filter_word_type word);
      int unsigned total;
      int unsigned avg;
      int unsigned lo;
      int unsigned hi;
      int unsigned gap;
      word.fresh = 1'b0;
      if (shadow_enable) begin
         sample_hist[samp_fill] = to_hundredths(raw, shadow_full_scale);
         samp_fill++;
         if (samp_fill == SAMPLES_PER_BLOCK) begin
            samp_fill = 0;
            total = 0;
            foreach (sample_hist[i])
               total += sample_hist[i];
            block_means[block_count] = POS_W'(rounded_div(total, SAMPLES_PER_BLOCK));
            block_count++;
            if (block_count == BLOCKS_PER_WINDOW) begin
               block_count = 0;
               total = 0;
               lo = block_means[0];
               hi = block_means[0];
               foreach (block_means[i]) begin
                  total += block_means[i];
                  if (block_means[i] < lo)
                     lo = block_means[i];
                  if (block_means[i] > hi)
                     hi = block_means[i];
               end
               avg = rounded_div(total, BLOCKS_PER_WINDOW);
               gap = (avg >= lo) ? avg - lo : lo - avg;
               held_pos = (gap <= shadow_threshold) ? POS_W'(lo) : POS_W'(hi);
               word.fresh = 1'b1;
            end
         end
      end
      word.position = held_pos;
   endtask

   always @(posedge clock) begin : word_watch
      filter_word_type seen;
      filter_word_type want;
      if (reset) begin
         shadow_enable     = 1'b1;
         shadow_full_scale = FS_W'(4095);
         shadow_threshold  = THR_W'(1);
         foreach (sample_hist[i])
            sample_hist[i] = '0;
         foreach (block_means[i])
            block_means[i] = '0;
         samp_fill    = 0;
         block_count  = 0;
         held_pos     = '0;
         expected_words.delete();
      end else begin
         // returned word first, so a word cannot match one queued this edge
         if (rsp_valid && rsp_ready) begin
            seen.position = rsp_position;
            seen.fresh    = rsp_fresh;
            if (expected_words.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected word, position %0d fresh %0b",
                           $realtime, seen.position, seen.fresh);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               if (seen.position !== want.position || seen.fresh !== want.fresh) begin
                  if (mismatches < 10)
                     $display("%0t: word wrong, position %0d/%0d fresh %0b/%0b (exp/act)",
                              $realtime, want.position, seen.position,
                              want.fresh, seen.fresh);
                  mismatches++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE:     shadow_enable     = csr_wdata[0];
               CSR_FULL_SCALE: shadow_full_scale = csr_wdata[FS_W-1:0];
               CSR_THRESHOLD:  shadow_threshold  = csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            step_filter(req_raw_sample, want);
            expected_words.push_back(want);
         end
      end
      words_pending <= expected_words.size();
      fail_count    <= mismatches;
   end

endmodule : snap_filter_checker
`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the two-stage average-and-snap filter.
//
// A short directed run covers raw extremes, rounding at one half, raw above
// full scale, full scale zero, disabled samples, an unused register and a
// threshold above 100. Random phases then send whole windows of shaped
// samples (flat, one outlier block, ramp, noise) mixed with noise bursts,
// under changing register settings and sender/receiver idling, with a long
// receiver hold-off that backs the block up. The checker does the scoring.
// ----------------------------------------------------------------------------
module testbench
   import tsasf_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SPB         = SAMPLES_PER_BLOCK_DEF;
   localparam int WINDOW_LEN  = SAMPLES_PER_BLOCK_DEF * BLOCKS_PER_WINDOW_DEF;
   localparam int RAW_MAX     = (1 << RAW_W) - 1;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 180;

   typedef enum int {
      WIN_FLAT,
      WIN_OUTLIER,
      WIN_RAMP,
      WIN_NOISE
   } window_style_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [RAW_W-1:0]     req_raw_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [POS_W-1:0]     rsp_position;
   logic                 rsp_fresh;
   logic                 csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [CSR_DAT_W-1:0] csr_wdata      = '0;

   int                   words_pending;
   int                   fail_count;
   int                   send_idle      = 0;
   int                   recv_stall     = 0;
   int                   hold_asked     = 0;
   int                   hold_given     = 0;
   logic                 tb_enable      = 1'b1;
   logic [FS_W-1:0]      tb_full_scale  = FS_W'(4095);
   int                   enabled_sent   = 0;
   int                   phase_items    = 0;

   two_stage_average_snap_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_raw_sample (req_raw_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_position   (rsp_position),
      .rsp_fresh      (rsp_fresh),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   snap_filter_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_raw_sample (req_raw_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_position   (rsp_position),
      .rsp_fresh      (rsp_fresh),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .words_pending  (words_pending),
      .fail_count     (fail_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asked != hold_given) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_given++;
         end else if (reset) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   function automatic logic [CSR_DAT_W-1:0] pad_bits(int unsigned value, int unsigned w);
      int unsigned mask;
      mask = (1 << w) - 1;
      return CSR_DAT_W'(($urandom & ~mask) | (value & mask));
   endfunction

   task automatic send_word(input logic [RAW_W-1:0] raw);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_raw_sample <= raw;
      do @(posedge clock); while (!req_ready);
      if (tb_enable) begin
         enabled_sent++;
         phase_items++;
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ENABLE:     tb_enable     = data[0];
         CSR_FULL_SCALE: tb_full_scale = data[FS_W-1:0];
         default: ;
      endcase
   endtask

   // fills up to the next window boundary with shaped samples
   task automatic send_window;
      window_style_type style;
      int unsigned   fs;
      int unsigned   base;
      int unsigned   odd_blk;
      int unsigned   odd_lvl;
      int unsigned   ramp;
      int unsigned   blk;
      int            level;
      int            raw;
      fs      = (tb_full_scale == 0) ? 1 : tb_full_scale;
      style   = window_style_type'($urandom_range(3));
      base    = $urandom_range(fs);
      odd_blk = $urandom_range(BLOCKS_PER_WINDOW_DEF - 1);
      odd_lvl = $urandom_range(fs);
      ramp    = $urandom_range(fs / 40);
      do begin
         blk = (enabled_sent % WINDOW_LEN) / SPB;
         case (style)
            WIN_FLAT:    level = base;
            WIN_OUTLIER: level = (blk == odd_blk) ? odd_lvl : base;
            WIN_RAMP:    level = base + blk * ramp;
            default:     level = $urandom_range(RAW_MAX);
         endcase
         raw = level + int'($urandom_range(6)) - 3;
         if ($urandom_range(39) == 0)
            raw = $urandom_range(RAW_MAX);
         if (raw < 0)
            raw = 0;
         if (raw > RAW_MAX)
            raw = RAW_MAX;
         send_word(RAW_W'(raw));
      end while (enabled_sent % WINDOW_LEN != 0);
   endtask

   task automatic run_phase(input int idle, input int stall, input bit squeeze);
      send_idle = idle;
      recv_stall <= stall;
      phase_items = 0;
      if (squeeze)
         hold_asked <= hold_asked + 1;
      while (phase_items < PHASE_ITEMS) begin
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(12, 1)) send_word(RAW_W'($urandom));
         else
            send_window();
      end
      drain();
   endtask

   initial begin
      int wait_cycles;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: raw extremes and alternating bits
      send_word(12'h000);
      send_word(12'hFFF);
      send_word(12'hAAA);
      send_word(12'h555);
      send_word(12'h800);
      send_word(12'h001);
      send_word(12'hFFE);
      drain();

      // half-way rounding and raw above full scale
      write_reg(CSR_FULL_SCALE, 12'd200);
      send_word(12'd1);
      send_word(12'd3);
      send_word(12'd201);
      send_word(12'd200);
      send_word(12'hFFF);
      drain();

      // full scale zero behaves as one
      write_reg(CSR_FULL_SCALE, 12'd0);
      send_word(12'd0);
      send_word(12'd1);
      send_word(12'd2);
      drain();

      // disabled: held position only
      write_reg(CSR_ENABLE, 12'hFFE);
      send_word(12'hFFF);
      send_word(12'd7);
      drain();

      write_reg(CSR_UNUSED, 12'hFFF);
      write_reg(CSR_ENABLE, 12'h001);
      write_reg(CSR_THRESHOLD, 12'hF7F);
      write_reg(CSR_FULL_SCALE, 12'hFFF);
      send_window();
      drain();

      write_reg(CSR_THRESHOLD, pad_bits(0, THR_W));
      run_phase(0, 0, 1'b1);

      write_reg(CSR_FULL_SCALE, 12'd1);
      write_reg(CSR_THRESHOLD, pad_bits(100, THR_W));
      run_phase(51, 0, 1'b0);

      write_reg(CSR_FULL_SCALE, CSR_DAT_W'($urandom_range(RAW_MAX, 50)));
      write_reg(CSR_THRESHOLD, pad_bits($urandom_range(127), THR_W));
      run_phase(0, 51, 1'b1);

      write_reg(CSR_ENABLE, pad_bits(0, 1));
      repeat (8) send_word(RAW_W'($urandom));
      drain();
      write_reg(CSR_ENABLE, pad_bits(1, 1));
      write_reg(CSR_UNUSED, pad_bits($urandom, CSR_DAT_W));
      write_reg(CSR_FULL_SCALE, CSR_DAT_W'($urandom_range(RAW_MAX, 1)));
      write_reg(CSR_THRESHOLD, pad_bits($urandom_range(20), THR_W));
      run_phase(9, 9, 1'b0);

      recv_stall <= 0;
      wait_cycles = 0;
      while (words_pending != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      if (fail_count == 0 && words_pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule : testbench
`default_nettype wire
